/* design/bm3_pkg.sv */
// Shared types and constants for the 3x3 binary morphology block.
// Used by bm3_front, bm3_back and binary_morphology_3x3.
`timescale 1ns / 1ps

package bm3_pkg;

  // Configuration register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SPREAD_MODE  = 2'd0;
  localparam reg_idx_t REG_IMAGE_WIDTH  = 2'd1;
  localparam reg_idx_t REG_IMAGE_HEIGHT = 2'd2;

  localparam int IMAGE_WIDTH_W  = 10;
  localparam int IMAGE_HEIGHT_W = 11;
  localparam int CFG_DATA_W     = 11;
  localparam int RST_WIDTH      = 500;
  localparam int RST_HEIGHT     = 500;

  // Input item kinds (tuser)
  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  // spread_mode codes
  localparam logic MODE_SPREAD_WHITE = 1'b0;
  localparam logic MODE_SPREAD_BLACK = 1'b1;

  // Classified operation handed from the front to the back.
  // mask bit 3*col+row: col 0 left .. 2 right, row 0 top .. 2 bottom.
  typedef struct packed {
    logic       emit;
    logic       last;
    logic       pix;
    logic [8:0] mask;
  } bm3_op_t;

endpackage

/* design/bm3_front.sv */
// Front end: accepts stream items, tracks the frame position and
// classifies each item into a window operation. Depends on bm3_pkg.
`timescale 1ns / 1ps

module bm3_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 1024,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT + 2)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            restart,
  input  logic [CW-1:0]   w_last,
  input  logic [RW-1:0]   h,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_action,
  input  logic            in_pix,
  input  logic            q_full,
  output logic            push,
  output bm3_pkg::bm3_op_t op,
  output logic [CW-1:0]   addr
);
  import bm3_pkg::*;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          accept;
  logic          drop;
  logic          c_ge1, c_ge2;
  logic          r_lt_h, r_le_h, r_ge1, r_ge2, r_ge3;
  logic [2:0]    rows, cols;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign addr     = col;

  always_comb begin
    c_ge1  = (col != '0);
    c_ge2  = (col > CW'(1));
    r_lt_h = (row < h);
    r_le_h = (row <= h);
    r_ge1  = (row >= RW'(1));
    r_ge2  = (row >= RW'(2));
    r_ge3  = (row >= RW'(3));
    // flush inside the frame is dropped; while draining every item is a flush
    drop   = r_lt_h && (in_action == ACTION_FLUSH);
    push   = accept && !drop;
    if (c_ge1) begin
      op.emit = r_ge1;
      rows    = {r_lt_h, 1'b1, r_ge2};
      cols    = {1'b1, 1'b1, c_ge2};
    end else begin
      // center sits at the end of the previous row
      op.emit = r_ge2;
      rows    = {r_le_h, 1'b1, r_ge3};
      cols    = {1'b0, 1'b1, 1'b1};
    end
    op.mask = {cols[2] ? rows : 3'b000, cols[1] ? rows : 3'b000,
               cols[0] ? rows : 3'b000};
    op.last = (row > h);
    op.pix  = r_lt_h ? in_pix : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      if (op.last) begin
        col <= '0;
        row <= '0;
      end else if (col == w_last) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  a_last_at_row_start: assert property (@(posedge clk) disable iff (rst)
    (push && op.last) |-> (col == '0))
    else $error("frame end seen away from column zero");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row <= h + RW'(1))
    else $error("row counter ran past the drain row");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    col <= w_last)
    else $error("column counter ran past the row end");

endmodule

/* design/bm3_queue.sv */
// Short FIFO between the front end and the back end.
// Generic payload; no package dependency.
`timescale 1ns / 1ps

module bm3_queue #(
  parameter int DATA_W = 21,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [NW-1:0]     count;
  logic              do_push, do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

/* design/bm3_back.sv */
// Back end: line stores, 3x3 window, decision logic and output register.
// Depends on bm3_pkg for the operation type and mode codes.
`timescale 1ns / 1ps

module bm3_back #(
  parameter int MAX_WIDTH = 512,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            restart,
  input  logic            spread_mode,
  input  logic            q_valid,
  input  bm3_pkg::bm3_op_t q_op,
  input  logic [CW-1:0]   q_addr,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_white,
  output logic            out_last
);
  import bm3_pkg::*;

  logic          line_upper  [MAX_WIDTH];
  logic          line_middle [MAX_WIDTH];

  logic          b_valid;
  bm3_op_t       b_op;
  logic [CW-1:0] b_addr;
  logic          top_q, mid_q;
  logic          b_fire;
  logic [8:0]    win, win_next, masked;
  logic          res;

  assign b_fire = b_valid && (!b_op.emit || !out_valid || out_ready);
  assign q_pop  = q_valid && (!b_valid || b_fire);

  always_comb begin
    win_next = {b_op.pix, mid_q, top_q, win[8:3]};
    masked   = win_next & b_op.mask;
    if (spread_mode == MODE_SPREAD_BLACK) begin
      res = &(masked | ~b_op.mask);
    end else begin
      res = |masked;
    end
  end

  // read the stores as the item enters the stage, write back as it leaves
  always_ff @(posedge clk) begin
    if (q_pop) begin
      top_q <= line_upper[q_addr];
      mid_q <= line_middle[q_addr];
    end
    if (b_fire) begin
      line_upper[b_addr]  <= mid_q;
      line_middle[b_addr] <= b_op.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_op   <= q_op;
      b_addr <= q_addr;
    end
    if (b_fire && b_op.emit) begin
      out_white <= res;
      out_last  <= b_op.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      win       <= '0;
    end else begin
      if (q_pop) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire && b_op.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (restart) begin
        win <= '0;
      end else if (b_fire) begin
        win <= b_op.last ? '0 : win_next;
      end
    end
  end

endmodule

/* design/binary_morphology_3x3.sv */
// 3x3 binary erosion/dilation on a raster pixel stream. Takes one pixel per
// clock (tuser 0) if not stalled and returns the processed pixel for each
// frame position, one row plus one pixel behind the input; after the last
// pixel of a frame, send row-plus-one flush transactions (tuser 1) to drain
// it, the final output carrying tlast. Flush transactions inside a frame are
// dropped and pixels sent while draining count as flushes. Unstalled, the
// sustained rate is one transaction per clock: each line store does one read
// and one write per clock in a two-step read/write-back stage, fed from a
// four-entry queue. Writes to config registers 0 to 2 restart the frame; line
// stores are kept. Depends on bm3_pkg, bm3_front, bm3_queue and bm3_back.
`timescale 1ns / 1ps

module binary_morphology_3x3 #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] pixel_white
  input  logic                          s_axis_tuser,  // [0] action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [0] out_white
  output logic                          m_axis_tlast,
  input  logic                          cfg_we,
  input  bm3_pkg::reg_idx_t             cfg_index,
  input  logic [bm3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bm3_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT + 2);
  localparam int W_RST   = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int H_RST   = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;
  localparam int OP_W    = $bits(bm3_op_t);
  localparam int Q_W     = CW + OP_W;
  localparam int Q_DEPTH = 4;

  logic          spread_mode;
  logic [CW-1:0] w_last, w_last_next;
  logic [RW-1:0] h, h_next;
  logic [31:0]   w_clamp, h_clamp;
  logic          restart;

  logic          push, q_full, q_empty, q_pop;
  bm3_op_t       f_op, q_op;
  logic [CW-1:0] f_addr, q_addr;
  logic [Q_W-1:0] q_rd;
  logic          out_white;

  // clamp sizes into the supported range as they are written
  always_comb begin
    w_clamp = 32'(cfg_data[IMAGE_WIDTH_W-1:0]);
    if (w_clamp < 32'd2) w_clamp = 32'd2;
    if (w_clamp > 32'(MAX_WIDTH)) w_clamp = 32'(MAX_WIDTH);
    h_clamp = 32'(cfg_data[IMAGE_HEIGHT_W-1:0]);
    if (h_clamp < 32'd2) h_clamp = 32'd2;
    if (h_clamp > 32'(MAX_HEIGHT)) h_clamp = 32'(MAX_HEIGHT);
    w_last_next = CW'(w_clamp - 32'd1);
    h_next      = RW'(h_clamp);
    restart     = cfg_we && (cfg_index == REG_SPREAD_MODE ||
                             cfg_index == REG_IMAGE_WIDTH ||
                             cfg_index == REG_IMAGE_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spread_mode <= MODE_SPREAD_WHITE;
      w_last      <= CW'(W_RST - 1);
      h           <= RW'(H_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPREAD_MODE:  spread_mode <= cfg_data[0];
        REG_IMAGE_WIDTH:  w_last      <= w_last_next;
        REG_IMAGE_HEIGHT: h           <= h_next;
        default: ;
      endcase
    end
  end

  bm3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .w_last    (w_last),
    .h         (h),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .in_pix    (s_axis_tdata[0]),
    .q_full    (q_full),
    .push      (push),
    .op        (f_op),
    .addr      (f_addr)
  );

  bm3_queue #(
    .DATA_W (Q_W),
    .DEPTH  (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data ({f_addr, f_op}),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  assign q_op   = q_rd[OP_W-1:0];
  assign q_addr = q_rd[Q_W-1:OP_W];

  bm3_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .spread_mode (spread_mode),
    .q_valid     (!q_empty),
    .q_op        (q_op),
    .q_addr      (q_addr),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_white   (out_white),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, out_white};

endmodule
